FILE: hw/rtl/lcg48_pkg.sv
// ----------------------------------------------------------------------------
// lcg48_pkg
// Shared types, constants and limb helpers for the 48-bit LCG unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lcg48_pkg;

    localparam int LIMB_W     = 16;
    localparam int STATE_W    = 48;
    localparam int ACC_W      = 96;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 80;
    localparam int OP_W       = 3;
    localparam int STEP_W     = 4;

    localparam logic [OP_W-1:0] OP_RESEED   = 3'd0;
    localparam logic [OP_W-1:0] OP_FRACTION = 3'd1;
    localparam logic [OP_W-1:0] OP_UNSIGNED = 3'd2;
    localparam logic [OP_W-1:0] OP_SIGNED   = 3'd3;
    localparam logic [OP_W-1:0] OP_RANGE    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADDEND     = 1'd1;

    localparam logic [STATE_W-1:0] MULT_RESET   = 48'h0005_DEEC_E66D;
    localparam logic [15:0]        ADDEND_RESET = 16'h000B;
    localparam logic [15:0]        SEED_LOW     = 16'h330E;
    localparam logic [31:0]        INT_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0]        INT_MIN      = 32'h8000_0000;

    localparam logic [STEP_W-1:0] LCG_LAST_STEP   = 4'd5;
    localparam logic [STEP_W-1:0] RANGE_LAST_STEP = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_STEP_FIN,
        ST_RANGE,
        ST_RANGE_FIN,
        ST_RESULT
    } fsm_t;

    typedef struct packed {
        logic [1:0] a;
        logic [1:0] b;
    } limb_pair_t;

    // Partial products that land below bit 48 of the state product
    function automatic limb_pair_t lcg_pair(input logic [STEP_W-1:0] step);
        limb_pair_t p;
        case (step)
            4'd0:    p = '{a: 2'd0, b: 2'd0};
            4'd1:    p = '{a: 2'd0, b: 2'd1};
            4'd2:    p = '{a: 2'd1, b: 2'd0};
            4'd3:    p = '{a: 2'd0, b: 2'd2};
            4'd4:    p = '{a: 2'd1, b: 2'd1};
            default: p = '{a: 2'd2, b: 2'd0};
        endcase
        return p;
    endfunction

    // All nine partial products of span times state
    function automatic limb_pair_t range_pair(input logic [STEP_W-1:0] step);
        limb_pair_t p;
        case (step)
            4'd0:    p = '{a: 2'd0, b: 2'd0};
            4'd1:    p = '{a: 2'd0, b: 2'd1};
            4'd2:    p = '{a: 2'd0, b: 2'd2};
            4'd3:    p = '{a: 2'd1, b: 2'd0};
            4'd4:    p = '{a: 2'd1, b: 2'd1};
            4'd5:    p = '{a: 2'd1, b: 2'd2};
            4'd6:    p = '{a: 2'd2, b: 2'd0};
            4'd7:    p = '{a: 2'd2, b: 2'd1};
            default: p = '{a: 2'd2, b: 2'd2};
        endcase
        return p;
    endfunction

    function automatic logic [LIMB_W-1:0] limb16(input logic [STATE_W-1:0] v,
                                                 input logic [1:0] k);
        logic [LIMB_W-1:0] r;
        case (k)
            2'd0:    r = v[15:0];
            2'd1:    r = v[31:16];
            default: r = v[47:32];
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lcg48_random_generator_unit.sv
// ----------------------------------------------------------------------------
// lcg48_random_generator_unit
// 48-bit linear congruential generator with fraction, integer and range draws.
// ----------------------------------------------------------------------------
// Reseed: loads the state with no result; the unit stays ready for the next item.
// Fraction, unsigned and signed draws: the sequencer steps through ST_STEP and
// ST_STEP_FIN to ST_RESULT; no new item is taken until the unit is back in idle.
// Range draw: ST_RANGE and ST_RANGE_FIN come between ST_STEP_FIN and ST_RESULT.
// The steps use one shared 16x16 multiplier, one partial product a cycle.
// Synchronous reset loads the standard multiplier, addend and zero-seed state.
`default_nettype none

module lcg48_random_generator_unit (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // tdata: seed[31:0], range_low[63:32], range_high[95:64]
    input  wire  [lcg48_pkg::IN_DATA_W-1:0]      s_tdata,
    // tuser: operation[2:0]
    input  wire  [lcg48_pkg::OP_W-1:0]           s_tuser,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // tdata: fraction[47:0], int_value[79:48]
    output logic [lcg48_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [lcg48_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [lcg48_pkg::CFG_DATA_W-1:0]     cfg_data
);

    lcg48_pkg::fsm_t state_reg, state_next;

    logic [lcg48_pkg::STATE_W-1:0]    mult_reg, mult_next;
    logic [15:0]                      addend_reg, addend_next;
    logic [lcg48_pkg::STATE_W-1:0]    lcg_state_reg, lcg_state_next;
    logic [lcg48_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic [31:0]                      prod_reg, prod_next;
    logic [2:0]                       prod_sh_reg, prod_sh_next;
    logic                             pend_reg, pend_next;
    logic [lcg48_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [lcg48_pkg::OP_W-1:0]       op_reg, op_next;
    logic [31:0]                      lo_reg, lo_next;
    logic [33:0]                      spread_reg, spread_next;
    logic [lcg48_pkg::STATE_W-1:0]    span_reg, span_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [lcg48_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                             s_xfer;
    logic                             is_draw;
    logic                             out_free;
    lcg48_pkg::limb_pair_t            pair;
    logic [lcg48_pkg::LIMB_W-1:0]     mul_a;
    logic [lcg48_pkg::LIMB_W-1:0]     mul_b;
    logic [31:0]                      mul_prod;
    logic [lcg48_pkg::ACC_W-1:0]      aligned;
    logic [lcg48_pkg::ACC_W-1:0]      acc_sum;
    logic [33:0]                      span_mag;
    logic [34:0]                      lo_ext;
    logic [34:0]                      off_ext;
    logic [34:0]                      range_sum;
    logic [31:0]                      range_val;
    logic [31:0]                      int_val;

    assign s_tready  = (state_reg == lcg48_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign s_xfer   = s_tvalid && s_tready;
    assign is_draw  = s_tuser inside {lcg48_pkg::OP_FRACTION, lcg48_pkg::OP_UNSIGNED,
                                      lcg48_pkg::OP_SIGNED, lcg48_pkg::OP_RANGE};
    assign out_free = !m_tvalid_reg || m_tready;

    // shared multiplier
    assign pair     = (state_reg == lcg48_pkg::ST_RANGE) ? lcg48_pkg::range_pair(step_reg)
                                                         : lcg48_pkg::lcg_pair(step_reg);
    assign mul_a    = (state_reg == lcg48_pkg::ST_RANGE) ? lcg48_pkg::limb16(span_reg, pair.a)
                                                         : lcg48_pkg::limb16(mult_reg, pair.a);
    assign mul_b    = lcg48_pkg::limb16(lcg_state_reg, pair.b);
    assign mul_prod = mul_a * mul_b;

    assign aligned  = {64'd0, prod_reg} << {prod_sh_reg, 4'd0};
    assign acc_sum  = acc_reg + (pend_reg ? aligned : {lcg48_pkg::ACC_W{1'b0}});

    assign span_mag = spread_reg[33] ? (~spread_reg + 34'd1) : spread_reg;

    assign lo_ext    = {{3{lo_reg[31]}}, lo_reg};
    assign off_ext   = {2'b00, acc_reg[80:48]};
    assign range_sum = spread_reg[33] ? (lo_ext - off_ext) : (lo_ext + off_ext);

    always_comb begin
        if (!range_sum[34] && (range_sum[33:31] != 3'b000)) begin
            range_val = lcg48_pkg::INT_MAX;
        end else if (range_sum[34] && (range_sum[33:31] != 3'b111)) begin
            range_val = lcg48_pkg::INT_MIN;
        end else begin
            range_val = range_sum[31:0];
        end
    end

    always_comb begin
        case (op_reg)
            lcg48_pkg::OP_UNSIGNED: int_val = {1'b0, lcg_state_reg[46:16]};
            lcg48_pkg::OP_SIGNED:   int_val = lcg_state_reg[47:16];
            lcg48_pkg::OP_RANGE:    int_val = range_val;
            default:                int_val = 32'd0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lcg48_pkg::ST_IDLE: begin
                if (s_xfer && is_draw) begin
                    state_next = lcg48_pkg::ST_STEP;
                end
            end
            lcg48_pkg::ST_STEP: begin
                if (step_reg == lcg48_pkg::LCG_LAST_STEP) begin
                    state_next = lcg48_pkg::ST_STEP_FIN;
                end
            end
            lcg48_pkg::ST_STEP_FIN: begin
                state_next = (op_reg == lcg48_pkg::OP_RANGE) ? lcg48_pkg::ST_RANGE
                                                             : lcg48_pkg::ST_RESULT;
            end
            lcg48_pkg::ST_RANGE: begin
                if (step_reg == lcg48_pkg::RANGE_LAST_STEP) begin
                    state_next = lcg48_pkg::ST_RANGE_FIN;
                end
            end
            lcg48_pkg::ST_RANGE_FIN: begin
                state_next = lcg48_pkg::ST_RESULT;
            end
            lcg48_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = lcg48_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lcg48_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        mult_next      = mult_reg;
        addend_next    = addend_reg;
        lcg_state_next = lcg_state_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        prod_sh_next   = prod_sh_reg;
        pend_next      = pend_reg;
        step_next      = step_reg;
        op_next        = op_reg;
        lo_next        = lo_reg;
        spread_next    = spread_reg;
        span_next      = span_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lcg48_pkg::REG_MULTIPLIER: mult_next   = cfg_data;
                lcg48_pkg::REG_ADDEND:     addend_next = cfg_data[15:0];
                default:                   mult_next   = mult_reg;
            endcase
        end

        case (state_reg)
            lcg48_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    if (s_tuser == lcg48_pkg::OP_RESEED) begin
                        lcg_state_next = {s_tdata[31:0], lcg48_pkg::SEED_LOW};
                    end else if (is_draw) begin
                        acc_next    = {80'd0, addend_reg};
                        step_next   = '0;
                        pend_next   = 1'b0;
                        op_next     = s_tuser;
                        lo_next     = s_tdata[63:32];
                        spread_next = {{2{s_tdata[95]}}, s_tdata[95:64]}
                                    - {{2{s_tdata[63]}}, s_tdata[63:32]} + 34'd1;
                    end
                end
            end
            lcg48_pkg::ST_STEP, lcg48_pkg::ST_RANGE: begin
                prod_next    = mul_prod;
                prod_sh_next = {1'b0, pair.a} + {1'b0, pair.b};
                pend_next    = 1'b1;
                acc_next     = acc_sum;
                step_next    = step_reg + 4'd1;
            end
            lcg48_pkg::ST_STEP_FIN: begin
                lcg_state_next = acc_sum[47:0];
                pend_next      = 1'b0;
                acc_next       = '0;
                step_next      = '0;
                span_next      = {14'd0, span_mag};
            end
            lcg48_pkg::ST_RANGE_FIN: begin
                acc_next  = acc_sum;
                pend_next = 1'b0;
            end
            lcg48_pkg::ST_RESULT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {int_val, lcg_state_reg};
                end
            end
            default: begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lcg48_pkg::ST_IDLE;
            mult_reg      <= lcg48_pkg::MULT_RESET;
            addend_reg    <= lcg48_pkg::ADDEND_RESET;
            lcg_state_reg <= {32'd0, lcg48_pkg::SEED_LOW};
            pend_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mult_reg      <= mult_next;
            addend_reg    <= addend_next;
            lcg_state_reg <= lcg_state_next;
            pend_reg      <= pend_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        prod_sh_reg <= prod_sh_next;
        step_reg    <= step_next;
        op_reg      <= op_next;
        lo_reg      <= lo_next;
        spread_reg  <= spread_next;
        span_reg    <= span_next;
        m_tdata_reg <= m_tdata_next;
    end

    a_draw_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && is_draw) |=> !s_tready)
        else $error("draw transfer did not start the sequencer");

    a_reseed_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && (s_tuser == lcg48_pkg::OP_RESEED)) |=>
        (lcg_state_reg[15:0] == lcg48_pkg::SEED_LOW))
        else $error("reseed did not load the fixed low bits");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == lcg48_pkg::ST_RESULT))
        else $error("result raised outside the result state");

    a_range_fit: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == lcg48_pkg::ST_RESULT) && (op_reg == lcg48_pkg::OP_RANGE))
        |-> (acc_reg[95:81] == 15'd0))
        else $error("range product overflowed its width");

endmodule

`default_nettype wire
